@@ design/kmq_pkg.sv @@
// Shared types and codes for the keyed message queue.
package kmq_pkg;

  // Width of the fill counter and of the capacity register
  localparam int unsigned CNT_W = 7;

  // Operation codes carried in the mode field
  localparam logic [2:0] MODE_SEND  = 3'd0;
  localparam logic [2:0] MODE_RECV  = 3'd1;
  localparam logic [2:0] MODE_REPL  = 3'd2;
  localparam logic [2:0] MODE_FIND  = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  // Status codes of a result
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_REPLACED = 3'd2;
  localparam logic [2:0] ST_RETURNED = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  // Capacity register value after reset
  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] task_handle;
    logic [31:0] cmd_key;
    logic [15:0] msg_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [15:0]      handle_out;
    logic [CNT_W-1:0] fill_count;
    logic             is_empty;
    logic             is_full;
  } out_item_t;

  // One stored queue entry
  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] key;
    logic [15:0] id;
  } entry_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic probe;    // compare the cell against the pending item
    logic use_key;  // compare command key (else message id)
    logic occ;      // cell holds a live entry
    logic load;     // take the pending item
    logic shift;    // take the upper neighbor's entry
    logic sel;      // drive this cell's handle onto the result bus
  } cell_ctl_t;

endpackage

@@ design/kmq_cell.sv @@
// One queue slot: holds an entry, compares it, and shifts from its upper neighbor.
module kmq_cell (
  input  logic              clk_i,
  input  kmq_pkg::cell_ctl_t ctl_i,
  input  kmq_pkg::entry_t   item_i,
  input  kmq_pkg::entry_t   next_i,
  output kmq_pkg::entry_t   entry_o,
  output logic              hit_o,
  output logic [15:0]       handle_o
);

  kmq_pkg::entry_t entry_q;
  logic            hit_q;
  logic            hit_d;

  // Load a new item or take the neighbor's entry when the chain closes a gap
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      entry_q <= item_i;
    end else if (ctl_i.shift) begin
      entry_q <= next_i;
    end
  end

  // Compare against the pending item
  always_comb begin
    if (ctl_i.use_key) begin
      hit_d = ctl_i.occ && (entry_q.key == item_i.key);
    end else begin
      hit_d = ctl_i.occ && (entry_q.id == item_i.id);
    end
  end

  // Hold the match flag for the update cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.probe) begin
      hit_q <= hit_d;
    end
  end

  assign entry_o  = entry_q;
  assign hit_o    = hit_q;
  assign handle_o = ctl_i.sel ? entry_q.handle : 16'd0;

endmodule

@@ design/keyed_message_queue.sv @@
// Top level of the keyed message queue: sequencer, fill counter and cell chain.
//
// A bounded FIFO of (task handle, command key, message id) entries held in a
// chain of QUEUE_DEPTH cells, oldest in cell 0. In the compare state every
// occupied cell compares its key or id with the item at once; in the update
// state the newest match is picked, the chain loads or shifts down by one
// cell to close a gap, and the result is registered. The next item is
// accepted as the update state retires; a stalled output holds that state.
// The user must write capacity through the cfg port only while no item is in
// flight; the block itself does not enforce this. The limit in use saturates
// at QUEUE_DEPTH. Entries are reached only below the fill count, so no
// clearing pass runs after reset.
module keyed_message_queue #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  kmq_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output kmq_pkg::out_item_t         out_item_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [kmq_pkg::CNT_W-1:0]  cfg_data_i
);

  localparam int unsigned CntW  = kmq_pkg::CNT_W;
  localparam int unsigned LvlN  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntMax = (1 << CntW) - 1;
  localparam logic [CntW-1:0] DepthSat =
    CntW'((QUEUE_DEPTH > CntMax) ? CntMax : QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  kmq_pkg::in_item_t       in_q;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         cap_q;
  logic [CntW-1:0]         eff_lim;
  kmq_pkg::out_item_t      out_q, out_d;
  logic                    out_valid_q;
  logic                    in_acc;
  logic                    fire;
  logic                    full_now;
  kmq_pkg::entry_t         new_entry;
  kmq_pkg::entry_t         chain [QUEUE_DEPTH+1];
  kmq_pkg::cell_ctl_t      ctl [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]  hits;
  logic [QUEUE_DEPTH-1:0]  newer_hit;
  logic [QUEUE_DEPTH-1:0]  newest;
  logic [15:0]             cell_handle [QUEUE_DEPTH];
  logic [15:0]             sel_handle;
  logic                    any_hit;
  logic                    push_do, repl_do, recv_do, find_do;

  // Capacity register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= kmq_pkg::CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  assign eff_lim  = (cap_q > DepthSat) ? DepthSat : cap_q;
  assign full_now = (count_q >= eff_lim);

  // Handshake: accept when idle, or when the update cycle retires
  assign fire       = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == S_IDLE) || fire);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) begin
        state_d = S_SRCH;
      end
      S_SRCH: state_d = S_EXEC;
      S_EXEC: if (fire) begin
        state_d = in_acc ? S_SRCH : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the pending item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_item_i;
    end
  end

  assign new_entry = '{handle: in_q.task_handle, key: in_q.cmd_key, id: in_q.msg_id};

  // Find the newest match: flag every cell that has a match above it
  always_comb begin
    newer_hit = hits >> 1;
    for (int k = 0; k < LvlN; k++) begin
      newer_hit = newer_hit | (newer_hit >> (1 << k));
    end
  end

  assign any_hit = |hits;
  assign newest  = hits & ~newer_hit;

  // Gather the selected handle
  always_comb begin
    sel_handle = 16'd0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sel_handle = sel_handle | cell_handle[i];
    end
  end

  // Decide the operation and the result
  always_comb begin
    push_do = 1'b0;
    repl_do = 1'b0;
    recv_do = 1'b0;
    find_do = 1'b0;
    count_d = count_q;
    out_d.status     = kmq_pkg::ST_NONE;
    out_d.handle_out = 16'd0;
    unique case (in_q.mode)
      kmq_pkg::MODE_SEND: begin
        push_do = !full_now;
        out_d.status = full_now ? kmq_pkg::ST_FULL : kmq_pkg::ST_ADDED;
      end
      kmq_pkg::MODE_RECV: begin
        if (count_q != '0) begin
          recv_do = 1'b1;
          out_d.status = kmq_pkg::ST_RETURNED;
          out_d.handle_out = sel_handle;
        end
      end
      kmq_pkg::MODE_REPL: begin
        if (any_hit) begin
          repl_do = 1'b1;
          out_d.status = kmq_pkg::ST_REPLACED;
          out_d.handle_out = sel_handle;
        end else begin
          push_do = !full_now;
          out_d.status = full_now ? kmq_pkg::ST_FULL : kmq_pkg::ST_ADDED;
        end
      end
      kmq_pkg::MODE_FIND: begin
        if (any_hit) begin
          find_do = 1'b1;
          out_d.status = kmq_pkg::ST_RETURNED;
          out_d.handle_out = sel_handle;
        end
      end
      kmq_pkg::MODE_CLEAR: count_d = '0;
      default: ;
    endcase
    if (push_do) begin
      count_d = count_q + 1'b1;
    end else if (recv_do || find_do) begin
      count_d = count_q - 1'b1;
    end
    out_d.fill_count = count_d;
    out_d.is_empty   = (count_d == '0);
    out_d.is_full    = (count_d >= eff_lim);
  end

  // Fill counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire) begin
      count_q <= count_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Cell chain; the top cell shifts in a blank entry
  assign chain[QUEUE_DEPTH] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    always_comb begin
      ctl[i].probe   = (state_q == S_SRCH);
      ctl[i].use_key = (in_q.mode == kmq_pkg::MODE_REPL);
      ctl[i].occ     = (int'(count_q) > i);
      ctl[i].load    = fire && ((push_do && (int'(count_q) == i)) ||
                                (repl_do && newest[i]));
      ctl[i].shift   = fire && (recv_do || (find_do && !newer_hit[i]));
      ctl[i].sel     = (in_q.mode == kmq_pkg::MODE_RECV) ? (i == 0) : newest[i];
    end

    kmq_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl[i]),
      .item_i   (new_entry),
      .next_i   (chain[i+1]),
      .entry_o  (chain[i]),
      .hit_o    (hits[i]),
      .handle_o (cell_handle[i])
    );
  end

`ifndef NO_ASSERTIONS
  // The compare cycle always leads to the update cycle
  a_srch_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |=> state_q == S_EXEC)
    else $error("compare cycle not followed by update cycle");

  // A retiring item always shows a result next cycle
  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("retired item left no result");

  // At most one newest match is picked
  a_newest_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> $onehot0(newest))
    else $error("more than one newest match");

  // The fill never passes the chain length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthSat)
    else $error("fill count beyond queue depth");

  // The fill count only moves when an item retires
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(count_q))
    else $error("fill count changed without an item");
`endif

endmodule
